// ----- hdl/sactl_pkg.sv -----
// sactl_pkg: shared constants for the set-associative tag/lru lookup block
// defaults for the top-level parameters, config register codes and field widths
// no dependencies
`default_nettype none

package sactl_pkg;

    // parameter defaults
    localparam int MAX_SETS_DEF   = 64;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 16;

    // fixed field widths
    localparam int WAY_W      = 3;
    localparam int CNT_W      = 32;
    localparam int OFFSET_W   = 4;
    localparam int SETB_W     = 3;
    localparam int WAYS_W     = 4;
    localparam int SHIFT_W    = 5;
    localparam int SET_RAW_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // config reset values
    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [SETB_W-1:0]   SET_BITS_RST    = 3'd3;
    localparam logic [WAYS_W-1:0]   WAYS_IN_USE_RST = 4'd1;

endpackage

`default_nettype wire

// ----- hdl/sactl_ram.sv -----
// sactl_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address collision; no reset on contents
// no dependencies
`default_nettype none

module sactl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/set_assoc_cache_tag_lru_top.sv -----
// set_assoc_cache_tag_lru_top: set-associative tag lookup with matrix lru replacement
// uses sactl_pkg for constants and sactl_ram for the tag, valid and lru row stores
// an accepted beat passes the s1 stage registers, then the done register, before its done strobe
// throughput: one beat per cycle; the tag, valid and lru rams are read at accept and
//   written back at the next edge, a one-row forward register covers the same set back to back
// reset: config returns to offset 4, set bits 3, one way; counters and per-set used flags
//   clear at once; ram contents are left as they are and a set reads as empty until its
//   first write, so there is no clearing pass
// the receiver cannot stall: each result shows for exactly one cycle
`default_nettype none

module set_assoc_cache_tag_lru_top #(
    parameter int MAX_SETS   = sactl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sactl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sactl_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // command side
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [ADDR_WIDTH-1:0]                  address,
    // result side
    output logic                                        done,
    output logic                                        is_hit,
    output logic [sactl_pkg::WAY_W-1:0]                 way_used,
    output logic [sactl_pkg::CNT_W-1:0]                 hit_total,
    output logic [sactl_pkg::CNT_W-1:0]                 miss_total,
    // config write port
    input  wire logic                                   cfg_write,
    input  wire logic [sactl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sactl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int TAG_ROW_W  = MAX_WAYS * ADDR_WIDTH;
    localparam int LRU_ROW_W  = MAX_WAYS * MAX_WAYS;
    localparam int SET_TAB_N  = 2 ** sactl_pkg::SET_RAW_W;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [sactl_pkg::OFFSET_W-1:0] offset_bits_reg;
    logic [sactl_pkg::SETB_W-1:0]   set_bits_reg;
    logic [sactl_pkg::WAYS_W-1:0]   ways_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= sactl_pkg::OFFSET_BITS_RST;
            set_bits_reg    <= sactl_pkg::SET_BITS_RST;
            ways_in_use_reg <= sactl_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sactl_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[sactl_pkg::OFFSET_W-1:0];
                sactl_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[sactl_pkg::SETB_W-1:0];
                sactl_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[sactl_pkg::WAYS_W-1:0];
                default:
                begin
                    // unmapped index, write is dropped
                end
            endcase
        end
    end

    // effective associativity: zero reads as one, large values clamp
    logic [sactl_pkg::WAYS_W-1:0] ways_eff;
    logic [MAX_WAYS-1:0]          way_mask;

    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            ways_eff = sactl_pkg::WAYS_W'(1);
        end
        else if (ways_in_use_reg > sactl_pkg::WAYS_W'(MAX_WAYS))
        begin
            ways_eff = sactl_pkg::WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = ways_in_use_reg;
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_mask[w] = (sactl_pkg::WAYS_W'(w) < ways_eff);
        end
    end

    // ------------------------------------------------------------------
    // accept stage: split the address, launch the row reads
    // ------------------------------------------------------------------
    logic accept;
    assign accept = start && !busy;

    // the block takes a beat every cycle
    assign busy = 1'b0;

    logic [ADDR_WIDTH-1:0]             addr_shifted;
    logic [7:0]                        set_mask_wide;
    logic [sactl_pkg::SET_RAW_W-1:0]   set_raw;
    logic [SET_W-1:0]                  set_in;
    logic [sactl_pkg::SHIFT_W-1:0]     tag_shift;
    logic [ADDR_WIDTH-1:0]             tag_in;

    // set index reduced modulo the set count, as a constant table
    logic [SET_W-1:0] set_mod_tab [SET_TAB_N];

    for (genvar g = 0; g < SET_TAB_N; g++)
    begin : g_set_mod
        localparam int SET_MOD = g % MAX_SETS;
        assign set_mod_tab[g] = SET_W'(SET_MOD);
    end

    always_comb
    begin
        addr_shifted  = address >> offset_bits_reg;
        set_mask_wide = (8'd1 << set_bits_reg) - 8'd1;
        set_raw       = addr_shifted[sactl_pkg::SET_RAW_W-1:0]
                        & set_mask_wide[sactl_pkg::SET_RAW_W-1:0];
        set_in        = set_mod_tab[set_raw];
        tag_shift     = sactl_pkg::SHIFT_W'(offset_bits_reg)
                        + sactl_pkg::SHIFT_W'(set_bits_reg);
        // shifting past the top leaves a zero tag
        tag_in        = address >> tag_shift;
    end

    // one flag per set, cleared at reset; until a set is first written its ram rows
    // are ignored and the set reads as empty
    logic [MAX_SETS-1:0]   set_used_reg;

    logic                  s1_valid_reg;
    logic [SET_W-1:0]      s1_set_reg;
    logic [ADDR_WIDTH-1:0] s1_tag_reg;
    logic                  s1_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg  <= set_in;
            s1_tag_reg  <= tag_in;
            s1_used_reg <= set_used_reg[set_in];
        end
    end

    // ------------------------------------------------------------------
    // row stores
    // ------------------------------------------------------------------
    logic [TAG_ROW_W-1:0] tag_rdata;
    logic [TAG_ROW_W-1:0] tag_row_next;
    logic [LRU_ROW_W-1:0] lru_rdata;
    logic [LRU_ROW_W-1:0] lru_row_next;
    logic [MAX_WAYS-1:0]  valid_rdata;
    logic [MAX_WAYS-1:0]  valid_row_next;

    sactl_ram #(
        .WIDTH (TAG_ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_set_reg),
        .wdata (tag_row_next),
        .raddr (set_in),
        .rdata (tag_rdata)
    );

    sactl_ram #(
        .WIDTH (MAX_WAYS),
        .DEPTH (MAX_SETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_set_reg),
        .wdata (valid_row_next),
        .raddr (set_in),
        .rdata (valid_rdata)
    );

    sactl_ram #(
        .WIDTH (LRU_ROW_W),
        .DEPTH (MAX_SETS)
    ) u_lru_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_set_reg),
        .wdata (lru_row_next),
        .raddr (set_in),
        .rdata (lru_rdata)
    );

    logic [MAX_WAYS-1:0] valid_row;

    // last row written, for a beat that read the ram in the same cycle
    logic                  fwd_valid_reg;
    logic [SET_W-1:0]      fwd_set_reg;
    logic [TAG_ROW_W-1:0]  fwd_tags_reg;
    logic [MAX_WAYS-1:0]   fwd_vbits_reg;
    logic [LRU_ROW_W-1:0]  fwd_lru_reg;

    // ------------------------------------------------------------------
    // lookup stage: compare, pick the way, update lru
    // ------------------------------------------------------------------
    logic                        fwd_hit;
    logic [TAG_ROW_W-1:0]        row_tags;
    logic [LRU_ROW_W-1:0]        row_lru;
    logic                        hit;
    logic [sactl_pkg::WAY_W-1:0] hit_way;
    logic [sactl_pkg::WAY_W-1:0] victim_way;
    logic [sactl_pkg::WAY_W-1:0] way_sel;
    logic [MAX_WAYS-1:0]         lru_row_bits;

    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_set_reg == s1_set_reg);

        if (fwd_hit)
        begin
            row_tags  = fwd_tags_reg;
            valid_row = fwd_vbits_reg;
            row_lru   = fwd_lru_reg;
        end
        else if (s1_used_reg)
        begin
            row_tags  = tag_rdata;
            valid_row = valid_rdata;
            row_lru   = lru_rdata;
        end
        else
        begin
            row_tags  = tag_rdata;
            valid_row = '0;
            row_lru   = '0;
        end

        // lowest searched way with a matching valid tag
        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (way_mask[w] && valid_row[w]
                && (row_tags[w*ADDR_WIDTH +: ADDR_WIDTH] == s1_tag_reg))
            begin
                hit     = 1'b1;
                hit_way = sactl_pkg::WAY_W'(w);
            end
        end

        // lowest searched way whose row, over the searched columns, is empty
        victim_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            lru_row_bits = row_lru[i*MAX_WAYS +: MAX_WAYS];
            if (way_mask[i] && ((lru_row_bits & way_mask) == '0))
            begin
                victim_way = sactl_pkg::WAY_W'(i);
            end
        end

        way_sel = hit ? hit_way : victim_way;

        // fill the victim on a miss
        tag_row_next   = row_tags;
        valid_row_next = valid_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!hit && (sactl_pkg::WAY_W'(w) == way_sel))
            begin
                tag_row_next[w*ADDR_WIDTH +: ADDR_WIDTH] = s1_tag_reg;
                valid_row_next[w]                        = 1'b1;
            end
        end

        // make way_sel most recent: its row set, its column cleared
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (sactl_pkg::WAY_W'(j) == way_sel)
                begin
                    lru_row_next[i*MAX_WAYS + j] = 1'b0;
                end
                else if (sactl_pkg::WAY_W'(i) == way_sel)
                begin
                    lru_row_next[i*MAX_WAYS + j] = 1'b1;
                end
                else
                begin
                    lru_row_next[i*MAX_WAYS + j] = row_lru[i*MAX_WAYS + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_used_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            set_used_reg[s1_set_reg] <= 1'b1;
            fwd_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fwd_set_reg   <= s1_set_reg;
            fwd_tags_reg  <= tag_row_next;
            fwd_vbits_reg <= valid_row_next;
            fwd_lru_reg   <= lru_row_next;
        end
    end

    // ------------------------------------------------------------------
    // result registers and running counts
    // ------------------------------------------------------------------
    logic                        done_reg;
    logic                        is_hit_reg;
    logic [sactl_pkg::WAY_W-1:0] way_used_reg;
    logic [sactl_pkg::CNT_W-1:0] hit_count_reg;
    logic [sactl_pkg::CNT_W-1:0] miss_count_reg;
    logic [sactl_pkg::CNT_W-1:0] hit_count_next;
    logic [sactl_pkg::CNT_W-1:0] miss_count_next;

    always_comb
    begin
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        if (s1_valid_reg)
        begin
            if (hit)
            begin
                hit_count_next = hit_count_reg + sactl_pkg::CNT_W'(1);
            end
            else
            begin
                miss_count_next = miss_count_reg + sactl_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
        end
        else
        begin
            done_reg       <= s1_valid_reg;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            is_hit_reg   <= hit;
            way_used_reg <= way_sel;
        end
    end

    // counters only move with a result, so they read as the totals for that beat
    assign done       = done_reg;
    assign is_hit     = is_hit_reg;
    assign way_used   = way_used_reg;
    assign hit_total  = hit_count_reg;
    assign miss_total = miss_count_reg;

endmodule

`default_nettype wire

// ----- hdl/sactl_checker.sv -----
// sactl_checker: port-level checks on the tag/lru lookup block's timing and counts
// uses sactl_pkg; bound onto set_assoc_cache_tag_lru_top below
`default_nettype none

module sactl_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic                          is_hit,
    input wire logic [sactl_pkg::CNT_W-1:0]   hit_total,
    input wire logic [sactl_pkg::CNT_W-1:0]   miss_total
);

    // every accepted beat is followed by its done strobe
    a_beat_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat gave no result");

    // no result without a matching accepted beat before it
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching beat");

    // a hit moves only the hit count, by one
    a_hit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_hit) |->
            (hit_total == $past(hit_total) + sactl_pkg::CNT_W'(1))
            && (miss_total == $past(miss_total)))
        else $error("hit count step wrong");

    // a miss moves only the miss count, by one
    a_miss_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_hit) |->
            (miss_total == $past(miss_total) + sactl_pkg::CNT_W'(1))
            && (hit_total == $past(hit_total)))
        else $error("miss count step wrong");

    // totals hold between results
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(hit_total) && $stable(miss_total)))
        else $error("totals moved without a result");

endmodule

bind set_assoc_cache_tag_lru_top sactl_checker u_sactl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .is_hit     (is_hit),
    .hit_total  (hit_total),
    .miss_total (miss_total)
);

`default_nettype wire

// ----- test/set_assoc_cache_tag_lru_checker.sv -----
// set_assoc_cache_tag_lru_checker: watches the lookup, result and config channels,
// keeps its own copy of tags, valid bits, lru matrix and counters, and compares results
// depends on sactl_pkg for the config register codes
module set_assoc_cache_tag_lru_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire logic [15:0]                      address,
    input  wire logic                             done,
    input  wire logic                             is_hit,
    input  wire logic [sactl_pkg::WAY_W-1:0]      way_used,
    input  wire logic [sactl_pkg::CNT_W-1:0]      hit_total,
    input  wire logic [sactl_pkg::CNT_W-1:0]      miss_total,
    input  wire logic                             cfg_write,
    input  wire logic [sactl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sactl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                    mismatches,
    output int                                    in_flight,
    output int                                    lookups_checked,
    output int                                    hits_checked
);

    localparam int NSETS = sactl_pkg::MAX_SETS_DEF;
    localparam int NWAYS = sactl_pkg::MAX_WAYS_DEF;

    typedef struct packed {
        logic                        hit;
        logic [sactl_pkg::WAY_W-1:0] way;
        logic [sactl_pkg::CNT_W-1:0] hits;
        logic [sactl_pkg::CNT_W-1:0] misses;
    } lookup_t;

    logic [15:0]                     tag_mirror [NSETS][NWAYS];
    bit                              line_valid [NSETS][NWAYS];
    bit [63:0]                       age_matrix [NSETS];
    bit [sactl_pkg::CNT_W-1:0]       hit_cnt;
    bit [sactl_pkg::CNT_W-1:0]       miss_cnt;
    bit [sactl_pkg::OFFSET_W-1:0]    cfg_offset;
    bit [sactl_pkg::SETB_W-1:0]      cfg_setb;
    bit [sactl_pkg::WAYS_W-1:0]      cfg_ways;
    lookup_t                         lookup_queue [$];

    // one lookup: tag compare, fill on miss, move the way to most recent
    function automatic lookup_t predict_lookup(input logic [15:0] addr);
        int          ways;
        int          shift;
        int          set_idx;
        int          way_sel;
        int          w;
        int          j;
        bit          found;
        bit          picked;
        bit [63:0]   col_mask;
        logic [15:0] tag;
        lookup_t     r;
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : int'(cfg_ways));
        set_idx = ((int'(addr) >> cfg_offset) & ((1 << cfg_setb) - 1)) % NSETS;
        shift = int'(cfg_offset) + int'(cfg_setb);
        tag = (shift >= 16) ? 16'h0 : 16'(int'(addr) >> shift);
        found = 1'b0;
        way_sel = 0;
        for (w = 0; w < ways; w++)
        begin
            if (!found && line_valid[set_idx][w] && tag_mirror[set_idx][w] == tag)
            begin
                found = 1'b1;
                way_sel = w;
            end
        end
        if (found)
        begin
            hit_cnt = hit_cnt + 1;
        end
        else
        begin
            miss_cnt = miss_cnt + 1;
            // lru way: its row, restricted to the searched ways, is all zero
            col_mask = (64'h1 << ways) - 64'h1;
            picked = 1'b0;
            for (w = 0; w < ways; w++)
            begin
                if (!picked && ((age_matrix[set_idx] >> (w * 8)) & col_mask) == 64'h0)
                begin
                    picked = 1'b1;
                    way_sel = w;
                end
            end
            tag_mirror[set_idx][way_sel] = tag;
            line_valid[set_idx][way_sel] = 1'b1;
        end
        // whole row set, whole column cleared, diagonal ends up zero
        for (j = 0; j < NWAYS; j++)
        begin
            age_matrix[set_idx][way_sel * 8 + j] = 1'b1;
            age_matrix[set_idx][j * 8 + way_sel] = 1'b0;
        end
        r.hit    = found;
        r.way    = way_sel[sactl_pkg::WAY_W-1:0];
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    task automatic report_field(input string field, input longint unsigned exp_val,
                                input longint unsigned act_val);
        mismatches++;
        $display("%0t checker: %s expected %0d actual %0d", $time, field, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t exp_r;
        if (!rst_n)
        begin
            for (int s = 0; s < NSETS; s++)
            begin
                age_matrix[s] = '0;
                for (int w = 0; w < NWAYS; w++)
                begin
                    tag_mirror[s][w] = '0;
                    line_valid[s][w] = 1'b0;
                end
            end
            hit_cnt         = '0;
            miss_cnt        = '0;
            cfg_offset      = sactl_pkg::OFFSET_BITS_RST;
            cfg_setb        = sactl_pkg::SET_BITS_RST;
            cfg_ways        = sactl_pkg::WAYS_IN_USE_RST;
            lookup_queue.delete();
            mismatches      = 0;
            in_flight       <= 0;
            lookups_checked <= 0;
            hits_checked    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (lookup_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t checker: result beat expected none actual one", $time);
                end
                else
                begin
                    exp_r = lookup_queue.pop_front();
                    if (is_hit !== exp_r.hit)
                        report_field("is_hit", exp_r.hit, is_hit);
                    if (way_used !== exp_r.way)
                        report_field("way_used", exp_r.way, way_used);
                    if (hit_total !== exp_r.hits)
                        report_field("hit_total", exp_r.hits, hit_total);
                    if (miss_total !== exp_r.misses)
                        report_field("miss_total", exp_r.misses, miss_total);
                    lookups_checked <= lookups_checked + 1;
                    if (exp_r.hit)
                        hits_checked <= hits_checked + 1;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    sactl_pkg::CFG_OFFSET_BITS: cfg_offset = cfg_data[sactl_pkg::OFFSET_W-1:0];
                    sactl_pkg::CFG_SET_BITS:    cfg_setb   = cfg_data[sactl_pkg::SETB_W-1:0];
                    sactl_pkg::CFG_WAYS_IN_USE: cfg_ways   = cfg_data[sactl_pkg::WAYS_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                lookup_queue.push_back(predict_lookup(address));
            in_flight <= lookup_queue.size();
        end
    end

endmodule

// ----- test/set_assoc_cache_tag_lru_top_tb.sv -----
// set_assoc_cache_tag_lru_top_tb: stimulus and verdict for the tag/lru lookup block
// depends on sactl_pkg, set_assoc_cache_tag_lru_top and set_assoc_cache_tag_lru_checker
module set_assoc_cache_tag_lru_top_tb;
    import sactl_pkg::*;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 19;
    localparam int PHASE_BEATS = 100;
    localparam int POOL_MAX    = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [15:0]           address;
    logic                  done;
    logic                  is_hit;
    logic [WAY_W-1:0]      way_used;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int in_flight;
    int lookups_checked;
    int hits_checked;
    int cycle_count;
    int settings_used;

    // shadow of the address split, used only to shape addresses
    int cur_offset;
    int cur_setb;

    // working set of lines for the current phase, so that hits and evictions happen
    logic [15:0] hot_lines [POOL_MAX];
    int          hot_count;

    set_assoc_cache_tag_lru_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .address    (address),
        .done       (done),
        .is_hit     (is_hit),
        .way_used   (way_used),
        .hit_total  (hit_total),
        .miss_total (miss_total),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    set_assoc_cache_tag_lru_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .address         (address),
        .done            (done),
        .is_hit          (is_hit),
        .way_used        (way_used),
        .hit_total       (hit_total),
        .miss_total      (miss_total),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .in_flight       (in_flight),
        .lookups_checked (lookups_checked),
        .hits_checked    (hits_checked)
    );

    always #6 clk = ~clk;

    // watchdog, well above the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t tb: timeout with %0d beats outstanding", $time, in_flight);
            $display("tb: failure");
            $finish;
        end
    end

    // one lookup beat; start stays high across back-to-back beats
    task automatic issue_lookup(input logic [15:0] addr, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        address <= addr;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // stop issuing, let every result come back, then a short hold-off
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // writes all three registers back to back; only called with the block idle
    task automatic configure(input int ofs, input int setb, input int ways);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_data  <= 4'(ofs);
        @(posedge clk);
        cfg_index <= CFG_SET_BITS;
        // top data bit is outside the field and must be ignored
        cfg_data  <= {1'($urandom_range(0, 1)), 3'(setb)};
        @(posedge clk);
        cfg_index <= CFG_WAYS_IN_USE;
        cfg_data  <= 4'(ways);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_offset = ofs;
        cur_setb   = setb;
        settings_used++;
    endtask

    // mostly short gaps, a few long ones, none at all when quiet
    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // reuse of a hot line, a conflicting tag in the same set, or a random address
    function automatic logic [15:0] next_address();
        int          roll;
        int          tag_shift;
        logic [15:0] line_mask;
        logic [15:0] tag_mask;
        logic [15:0] a;
        roll      = $urandom_range(0, 99);
        tag_shift = cur_offset + cur_setb;
        line_mask = 16'((32'h1 << cur_offset) - 1);
        tag_mask  = (tag_shift >= 16) ? 16'h0 : 16'(32'hffff << tag_shift);
        a = hot_lines[$urandom_range(0, hot_count - 1)];
        if (roll < 65)
            a = a ^ (16'($urandom) & line_mask);
        else if (roll < 85)
            a = a ^ (16'($urandom) & tag_mask);
        else
            a = 16'($urandom);
        return a;
    endfunction

    initial begin
        int ofs;
        int setb;
        int ways;
        bit quiet;
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        address       = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_OFFSET_BITS;
        cfg_data      = '0;
        cycle_count   = 0;
        settings_used = 1;
        cur_offset    = OFFSET_BITS_RST;
        cur_setb      = SET_BITS_RST;
        hot_count     = 1;
        hot_lines[0]  = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, one way: cold miss, hit, conflict eviction in set 0
        issue_lookup(16'h0000, 0);
        issue_lookup(16'h0000, 0);
        issue_lookup(16'hffff, 0);
        issue_lookup(16'h0080, 1);
        issue_lookup(16'h0000, 0);
        drain();

        // byte lines, one set, all eight ways: all-ones tag is an ordinary tag,
        // eight more tags push it out through the lru order
        configure(0, 0, 8);
        issue_lookup(16'hffff, 0);
        issue_lookup(16'hffff, 0);
        for (int i = 1; i <= 8; i++)
            issue_lookup(16'(i), 0);
        issue_lookup(16'hffff, 2);
        drain();

        // zero ways acts as one; offset and set fields run past the address
        configure(15, 7, 0);
        issue_lookup(16'h0000, 0);
        issue_lookup(16'h8000, 0);
        issue_lookup(16'h7fff, 0);
        issue_lookup(16'h8000, 0);
        drain();

        // way count above the maximum saturates
        configure(2, 6, 15);
        issue_lookup(16'h0004, 0);
        issue_lookup(16'hff00, 0);
        issue_lookup(16'h0005, 0);
        drain();

        // random phases, each with its own setting and working set
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin ofs = 0;  setb = 0; ways = 8;  end
                1:       begin ofs = 15; setb = 7; ways = 15; end
                2:       begin ofs = 0;  setb = 6; ways = 8;  end
                3:       begin ofs = 10; setb = 6; ways = 0;  end
                4:       begin ofs = 4;  setb = 3; ways = 1;  end
                5:       begin ofs = 9;  setb = 7; ways = 9;  end
                default: begin
                    ofs  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                       : $urandom_range(0, 8);
                    setb = $urandom_range(0, 7);
                    ways = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8);
                end
            endcase
            configure(ofs, setb, ways);
            hot_count = $urandom_range(2, POOL_MAX);
            for (int i = 0; i < hot_count; i++)
                hot_lines[i] = 16'($urandom);
            // some phases run with no gaps at all
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_BEATS; i++)
                issue_lookup(next_address(), pick_gap(quiet));
            drain();
        end

        $display("summary: %0d lookup beats checked, %0d hits, %0d misses",
                 lookups_checked, hits_checked, lookups_checked - hits_checked);
        $display("summary: %0d cache settings incl. zero and oversized way counts",
                 settings_used);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
